// File: sv/priority_task_scheduler_top_assert.svh
// ---------------------------------------------------------------------------
// Scheduler assertion macros
// Shared concurrent assertion forms used by the scheduler modules.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_TASK_SCHEDULER_TOP_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTS_ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PTS_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// File: sv/pts_pkg.sv
// ---------------------------------------------------------------------------
// Scheduler package
// Sizes, codes, word types and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package pts_pkg;

    localparam int MAX_TASKS       = 16;
    localparam int PRIORITY_LEVELS = 8;
    localparam int SLOT_W          = $clog2(MAX_TASKS);
    localparam int LVL_W           = $clog2(PRIORITY_LEVELS);
    localparam int CNT_W           = $clog2(MAX_TASKS + 1);
    localparam int ADDR_W          = LVL_W + SLOT_W;
    localparam int FIFO_DEPTH      = 1 << ADDR_W;

    typedef enum logic [2:0] {
        FN_CREATE   = 3'd0,
        FN_YIELD    = 3'd1,
        FN_BLOCK    = 3'd2,
        FN_UNBLOCK  = 3'd3,
        FN_DESTROY  = 3'd4,
        FN_SCHEDULE = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_FREE     = 3'd1,
        ST_BAD_PRIO    = 3'd2,
        ST_NO_ACTIVE   = 3'd3,
        ST_SLOT_UNUSED = 3'd4,
        ST_MISMATCH    = 3'd5,
        ST_NONE_READY  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        SS_FREE    = 2'd0,
        SS_BLOCKED = 2'd1,
        SS_READY   = 2'd2,
        SS_ACTIVE  = 2'd3
    } slot_state_t;

    typedef enum logic [1:0] {
        RS_KEEP = 2'd0,
        RS_ZERO = 2'd1,
        RS_REQ  = 2'd2
    } reason_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_PUSH,
        S_SCAN,
        S_OLD_SEL,
        S_OLD_CHK,
        S_OLD_PUSH,
        S_NEW_SEL,
        S_NEW_SET,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic [2:0] func;
        logic [3:0] task_id;
        logic [3:0] priority_req;
        logic [3:0] block_reason;
    } sched_req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] new_task_id;
        logic       active_valid;
        logic [3:0] active_task_id;
        logic       switched;
    } sched_rsp_t;

    typedef struct packed {
        logic        load;
        logic        slot_wr;
        slot_state_t new_state;
        reason_sel_t reason_sel;
        logic        prio_wr;
        logic        lvl_from_req;
        logic        lvl_from_slot;
        logic        push;
        logic        scan_start;
        logic        scan_pop;
        logic        scan_step;
        logic        sel_active;
        logic        sel_head;
        logic        set_active;
        logic        clear_active;
        logic        set_status;
        status_t     status_code;
        logic        set_new_id;
        logic        set_switched;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0]  func;
        logic        free_found;
        logic        prio_ok;
        logic        tid_ok;
        slot_state_t sel_state;
        logic        reason_match;
        logic        active_present;
        logic        active_match;
        logic        any_ready;
        logic        scan_done;
    } dp_stat_t;

endpackage

// File: sv/pts_dp.sv
// ---------------------------------------------------------------------------
// Scheduler datapath
// Slot table, ready queue memory with scan/shift engine and result registers.
// ---------------------------------------------------------------------------
`include "priority_task_scheduler_top_assert.svh"

module pts_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  pts_pkg::sched_req_t request,
    input  pts_pkg::dp_cmd_t   cmd,
    output pts_pkg::dp_stat_t  stat,
    output pts_pkg::sched_rsp_t result
);
    import pts_pkg::*;

    sched_req_t  op_reg;
    slot_state_t slot_state_reg [MAX_TASKS];
    logic [3:0]  slot_reason_reg [MAX_TASKS];
    logic [LVL_W-1:0] slot_prio_reg [MAX_TASKS];
    logic [CNT_W-1:0] count_reg [PRIORITY_LEVELS];
    logic [SLOT_W-1:0] fifo_mem [FIFO_DEPTH];

    logic [SLOT_W-1:0] sel_slot_reg;
    logic [LVL_W-1:0]  q_level_reg;
    logic              free_found_reg;
    logic              prio_ok_reg;
    logic              tid_ok_reg;
    logic              any_ready_reg;
    logic              active_present_reg;
    logic [SLOT_W-1:0] active_slot_reg;
    status_t           status_reg;
    logic [SLOT_W-1:0] new_id_reg;
    logic              switched_reg;

    logic [CNT_W-1:0]  rd_idx_reg;
    logic              rv_reg;
    logic              found_reg;
    logic              pop_reg;
    logic [SLOT_W-1:0] target_reg;
    logic [SLOT_W-1:0] didx_reg;
    logic [SLOT_W-1:0] head_reg;
    logic [SLOT_W-1:0] rd_data_reg;

    logic [SLOT_W-1:0] first_free;
    logic              any_free;
    logic [LVL_W-1:0]  top_level;
    logic              any_ready;
    logic [SLOT_W-1:0] sel_slot_next;
    logic [CNT_W-1:0]  cur_count;
    logic              issue;
    logic              scan_done;
    logic              hit;
    logic              mem_we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [SLOT_W-1:0] wdata;

    always_comb
    begin
        first_free = '0;
        any_free   = 1'b0;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
        begin
            if (slot_state_reg[i] == SS_FREE)
            begin
                first_free = SLOT_W'(i);
                any_free   = 1'b1;
            end
        end
    end

    always_comb
    begin
        top_level = '0;
        any_ready = 1'b0;
        for (int i = 0; i < PRIORITY_LEVELS; i++)
        begin
            if (count_reg[i] != '0)
            begin
                top_level = LVL_W'(i);
                any_ready = 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (request.func) inside
            FN_CREATE:          sel_slot_next = first_free;
            FN_YIELD, FN_BLOCK: sel_slot_next = active_slot_reg;
            default:            sel_slot_next = SLOT_W'(request.task_id);
        endcase
    end

    assign cur_count = count_reg[q_level_reg];
    assign issue     = cmd.scan_step && (rd_idx_reg < cur_count);
    assign scan_done = !(rd_idx_reg < cur_count) && !rv_reg;
    assign hit       = pop_reg ? (didx_reg == '0) : (rd_data_reg == target_reg);
    assign mem_we    = cmd.push || (cmd.scan_step && rv_reg && found_reg);
    assign waddr     = cmd.push ? {q_level_reg, cur_count[SLOT_W-1:0]}
                                : {q_level_reg, SLOT_W'(didx_reg - 1'b1)};
    assign wdata     = cmd.push ? sel_slot_reg : rd_data_reg;
    assign raddr     = {q_level_reg, rd_idx_reg[SLOT_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fifo_mem[waddr] <= wdata;
        end
        if (issue)
        begin
            rd_data_reg <= fifo_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= request;
        end
        if (cmd.prio_wr)
        begin
            slot_prio_reg[sel_slot_reg] <= LVL_W'(op_reg.priority_req);
        end
        if (cmd.scan_start)
        begin
            target_reg <= sel_slot_reg;
        end
        if (cmd.scan_step)
        begin
            didx_reg <= rd_idx_reg[SLOT_W-1:0];
            if (rv_reg && !found_reg && hit)
            begin
                head_reg <= rd_data_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                slot_state_reg[i]  <= SS_FREE;
                slot_reason_reg[i] <= '0;
            end
            for (int i = 0; i < PRIORITY_LEVELS; i++)
            begin
                count_reg[i] <= '0;
            end
            sel_slot_reg       <= '0;
            q_level_reg        <= '0;
            free_found_reg     <= 1'b0;
            prio_ok_reg        <= 1'b0;
            tid_ok_reg         <= 1'b0;
            any_ready_reg      <= 1'b0;
            active_present_reg <= 1'b0;
            active_slot_reg    <= '0;
            status_reg         <= ST_OK;
            new_id_reg         <= '0;
            switched_reg       <= 1'b0;
            rd_idx_reg         <= '0;
            rv_reg             <= 1'b0;
            found_reg          <= 1'b0;
            pop_reg            <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                sel_slot_reg   <= sel_slot_next;
                q_level_reg    <= top_level;
                free_found_reg <= any_free;
                prio_ok_reg    <= 32'(request.priority_req) < 32'(PRIORITY_LEVELS);
                tid_ok_reg     <= 32'(request.task_id) < 32'(MAX_TASKS);
                any_ready_reg  <= any_ready;
                status_reg     <= ST_OK;
                new_id_reg     <= '0;
                switched_reg   <= 1'b0;
            end
            else if (cmd.sel_active)
            begin
                sel_slot_reg <= active_slot_reg;
            end
            else if (cmd.sel_head)
            begin
                sel_slot_reg <= head_reg;
            end

            if (cmd.slot_wr)
            begin
                slot_state_reg[sel_slot_reg] <= cmd.new_state;
                case (cmd.reason_sel)
                    RS_ZERO: slot_reason_reg[sel_slot_reg] <= '0;
                    RS_REQ:  slot_reason_reg[sel_slot_reg] <= op_reg.block_reason;
                    default: ;
                endcase
            end

            if (cmd.lvl_from_req)
            begin
                q_level_reg <= LVL_W'(op_reg.priority_req);
            end
            else if (cmd.lvl_from_slot)
            begin
                q_level_reg <= slot_prio_reg[sel_slot_reg];
            end

            if (cmd.push)
            begin
                count_reg[q_level_reg] <= cur_count + 1'b1;
            end
            else if (cmd.scan_step && scan_done && found_reg)
            begin
                count_reg[q_level_reg] <= cur_count - 1'b1;
            end

            if (cmd.clear_active)
            begin
                active_present_reg <= 1'b0;
                active_slot_reg    <= '0;
            end
            else if (cmd.set_active)
            begin
                active_present_reg <= 1'b1;
                active_slot_reg    <= sel_slot_reg;
            end

            if (cmd.set_status)
            begin
                status_reg <= cmd.status_code;
            end
            if (cmd.set_new_id)
            begin
                new_id_reg <= sel_slot_reg;
            end
            if (cmd.set_switched)
            begin
                switched_reg <= 1'b1;
            end

            if (cmd.scan_start)
            begin
                rd_idx_reg <= '0;
                rv_reg     <= 1'b0;
                found_reg  <= 1'b0;
                pop_reg    <= cmd.scan_pop;
            end
            else if (cmd.scan_step)
            begin
                rd_idx_reg <= rd_idx_reg + CNT_W'(issue);
                rv_reg     <= issue;
                if (rv_reg && !found_reg && hit)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        stat.func           = op_reg.func;
        stat.free_found     = free_found_reg;
        stat.prio_ok        = prio_ok_reg;
        stat.tid_ok         = tid_ok_reg;
        stat.sel_state      = slot_state_reg[sel_slot_reg];
        stat.reason_match   = slot_reason_reg[sel_slot_reg] == op_reg.block_reason;
        stat.active_present = active_present_reg;
        stat.active_match   = active_present_reg && (active_slot_reg == sel_slot_reg);
        stat.any_ready      = any_ready_reg;
        stat.scan_done      = scan_done;
    end

    assign result.status         = status_reg;
    assign result.new_task_id    = 4'(new_id_reg);
    assign result.active_valid   = active_present_reg;
    assign result.active_task_id = active_present_reg ? 4'(active_slot_reg) : 4'd0;
    assign result.switched       = switched_reg;

    `PTS_ASSERT_IMPLY(a_push_room, clk, rst_n, cmd.push, cur_count < CNT_W'(MAX_TASKS))
    `PTS_ASSERT_IMPLY(a_scan_hit, clk, rst_n, cmd.scan_step && scan_done, found_reg)
    `PTS_ASSERT_IMPLY(a_active_live, clk, rst_n, active_present_reg, slot_state_reg[active_slot_reg] != SS_FREE)

endmodule

// File: sv/pts_ctrl.sv
// ---------------------------------------------------------------------------
// Scheduler controller
// Sequences each operation word through the datapath and raises the strobe.
// ---------------------------------------------------------------------------
`include "priority_task_scheduler_top_assert.svh"

module pts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pts_pkg::dp_stat_t stat,
    output pts_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              done
);
    import pts_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (stat.func)
                    FN_CREATE:
                    begin
                        if (!stat.free_found)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NO_FREE;
                        end
                        else if (!stat.prio_ok)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_BAD_PRIO;
                        end
                        else
                        begin
                            cmd.slot_wr      = 1'b1;
                            cmd.new_state    = SS_READY;
                            cmd.reason_sel   = RS_ZERO;
                            cmd.prio_wr      = 1'b1;
                            cmd.lvl_from_req = 1'b1;
                            cmd.set_new_id   = 1'b1;
                            state_next       = S_PUSH;
                        end
                    end
                    FN_YIELD:
                    begin
                        if (!stat.active_present)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NO_ACTIVE;
                        end
                        else
                        begin
                            cmd.slot_wr    = 1'b1;
                            cmd.new_state  = SS_READY;
                            cmd.reason_sel = RS_KEEP;
                        end
                    end
                    FN_BLOCK:
                    begin
                        if (!stat.active_present)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NO_ACTIVE;
                        end
                        else
                        begin
                            cmd.slot_wr    = 1'b1;
                            cmd.new_state  = SS_BLOCKED;
                            cmd.reason_sel = RS_REQ;
                        end
                    end
                    FN_UNBLOCK:
                    begin
                        if (!stat.tid_ok || stat.sel_state == SS_FREE)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_SLOT_UNUSED;
                        end
                        else if (stat.sel_state != SS_BLOCKED || !stat.reason_match)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_MISMATCH;
                        end
                        else
                        begin
                            cmd.slot_wr    = 1'b1;
                            cmd.new_state  = SS_READY;
                            cmd.reason_sel = RS_ZERO;
                            if (!stat.active_match)
                            begin
                                cmd.lvl_from_slot = 1'b1;
                                state_next        = S_PUSH;
                            end
                        end
                    end
                    FN_DESTROY:
                    begin
                        if (!stat.tid_ok || stat.sel_state == SS_FREE)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_SLOT_UNUSED;
                        end
                        else
                        begin
                            cmd.slot_wr    = 1'b1;
                            cmd.new_state  = SS_FREE;
                            cmd.reason_sel = RS_ZERO;
                            if (stat.active_match)
                            begin
                                cmd.clear_active = 1'b1;
                            end
                            else if (stat.sel_state == SS_READY)
                            begin
                                cmd.lvl_from_slot = 1'b1;
                                cmd.scan_start    = 1'b1;
                                state_next        = S_SCAN;
                            end
                        end
                    end
                    FN_SCHEDULE:
                    begin
                        if (!stat.any_ready)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NONE_READY;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_pop   = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = (stat.func == FN_SCHEDULE) ? S_OLD_SEL : S_DONE;
                end
            end
            S_OLD_SEL:
            begin
                cmd.sel_active = 1'b1;
                state_next     = S_OLD_CHK;
            end
            S_OLD_CHK:
            begin
                if (stat.active_present && stat.sel_state != SS_BLOCKED)
                begin
                    cmd.slot_wr       = 1'b1;
                    cmd.new_state     = SS_READY;
                    cmd.reason_sel    = RS_KEEP;
                    cmd.lvl_from_slot = 1'b1;
                    state_next        = S_OLD_PUSH;
                end
                else
                begin
                    state_next = S_NEW_SEL;
                end
            end
            S_OLD_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_NEW_SEL;
            end
            S_NEW_SEL:
            begin
                cmd.sel_head = 1'b1;
                state_next   = S_NEW_SET;
            end
            S_NEW_SET:
            begin
                cmd.slot_wr      = 1'b1;
                cmd.new_state    = SS_ACTIVE;
                cmd.reason_sel   = RS_KEEP;
                cmd.set_active   = 1'b1;
                cmd.set_switched = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;

    `PTS_ASSERT_NEXT(a_accept_exec, clk, rst_n, start && !busy, state_reg == S_EXEC)
    `PTS_ASSERT_NEXT(a_scan_hold, clk, rst_n, (state_reg == S_SCAN) && !stat.scan_done, state_reg == S_SCAN)

endmodule

// File: sv/priority_task_scheduler_top.sv
// ---------------------------------------------------------------------------
// Priority task scheduler
// Fixed-priority scheduler with one FIFO ready queue per level.
// ---------------------------------------------------------------------------
// A result word is strobed on done after its operation passes the exec state, and
// after a further push state when a create or unblock queues the task; destroying
// a queued task and schedule scan one queue entry per cycle. busy stays high through
// the strobe cycle, so the next word is accepted in the cycle after the strobe.
// Reset frees all slots, empties all queues and clears the active task.
// The receiver cannot stall: each result is valid for exactly one cycle.
module priority_task_scheduler_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  pts_pkg::sched_req_t request,
    output logic                busy,
    output logic                done,
    output pts_pkg::sched_rsp_t result
);
    import pts_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    pts_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

endmodule

// File: bench/tb_top.sv
// ---------------------------------------------------------------------------
// Scheduler testbench
// Drives create, yield, block, unblock, destroy, schedule and undefined-code
// words into the scheduler and checks every result word against a behavioral
// predictor of the slot table, the ready queues and the active task.
// ---------------------------------------------------------------------------
module tb_top;

    import pts_pkg::*;

    class sched_scoreboard;
        slot_state_t slot_st[MAX_TASKS];
        logic [2:0]  slot_pr[MAX_TASKS];
        logic [3:0]  slot_rs[MAX_TASKS];
        logic [3:0]  ready_q[PRIORITY_LEVELS][$];
        bit          act_on;
        logic [3:0]  act_id;
        sched_rsp_t  pending[$];
        int          errors;

        function void clear();
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                slot_st[i] = SS_FREE;
                slot_pr[i] = '0;
                slot_rs[i] = '0;
            end
            for (int l = 0; l < PRIORITY_LEVELS; l++)
                ready_q[l].delete();
            act_on = 0;
            act_id = '0;
            pending.delete();
            errors = 0;
        endfunction

        function void enqueue(int s);
            ready_q[slot_pr[s]].push_back(s[3:0]);
        endfunction

        function void note_request(sched_req_t rq);
            sched_rsp_t r;
            int slot;
            int lvl;
            logic [3:0] hd;
            r = '0;
            r.status = ST_OK;
            case (rq.func)
                FN_CREATE:
                begin
                    slot = -1;
                    for (int i = MAX_TASKS - 1; i >= 0; i--)
                        if (slot_st[i] == SS_FREE)
                            slot = i;
                    if (slot < 0)
                        r.status = ST_NO_FREE;
                    else if (rq.priority_req >= PRIORITY_LEVELS)
                        r.status = ST_BAD_PRIO;
                    else
                    begin
                        slot_st[slot] = SS_READY;
                        slot_pr[slot] = rq.priority_req[2:0];
                        slot_rs[slot] = '0;
                        enqueue(slot);
                        r.new_task_id = slot[3:0];
                    end
                end
                FN_YIELD, FN_BLOCK:
                begin
                    if (!act_on)
                        r.status = ST_NO_ACTIVE;
                    else if (rq.func == FN_YIELD)
                        slot_st[act_id] = SS_READY;
                    else
                    begin
                        slot_st[act_id] = SS_BLOCKED;
                        slot_rs[act_id] = rq.block_reason;
                    end
                end
                FN_UNBLOCK:
                begin
                    if (slot_st[rq.task_id] == SS_FREE)
                        r.status = ST_SLOT_UNUSED;
                    else if (slot_st[rq.task_id] != SS_BLOCKED ||
                             slot_rs[rq.task_id] != rq.block_reason)
                        r.status = ST_MISMATCH;
                    else
                    begin
                        slot_st[rq.task_id] = SS_READY;
                        slot_rs[rq.task_id] = '0;
                        if (!(act_on && act_id == rq.task_id))
                            enqueue(rq.task_id);
                    end
                end
                FN_DESTROY:
                begin
                    if (slot_st[rq.task_id] == SS_FREE)
                        r.status = ST_SLOT_UNUSED;
                    else
                    begin
                        if (act_on && act_id == rq.task_id)
                        begin
                            act_on = 0;
                            act_id = '0;
                        end
                        else if (slot_st[rq.task_id] == SS_READY)
                        begin
                            lvl = slot_pr[rq.task_id];
                            foreach (ready_q[lvl][k])
                                if (ready_q[lvl][k] == rq.task_id)
                                begin
                                    ready_q[lvl].delete(k);
                                    break;
                                end
                        end
                        slot_st[rq.task_id] = SS_FREE;
                        slot_rs[rq.task_id] = '0;
                    end
                end
                FN_SCHEDULE:
                begin
                    lvl = -1;
                    for (int l = 0; l < PRIORITY_LEVELS; l++)
                        if (ready_q[l].size() != 0)
                            lvl = l;
                    if (lvl < 0)
                        r.status = ST_NONE_READY;
                    else
                    begin
                        hd = ready_q[lvl].pop_front();
                        if (act_on && slot_st[act_id] != SS_BLOCKED)
                        begin
                            slot_st[act_id] = SS_READY;
                            enqueue(act_id);
                        end
                        act_id = hd;
                        act_on = 1;
                        slot_st[hd] = SS_ACTIVE;
                        r.switched = 1'b1;
                    end
                end
                default: ;
            endcase
            r.active_valid = act_on;
            r.active_task_id = act_on ? act_id : 4'd0;
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(sched_rsp_t got);
            sched_rsp_t want;
            if (pending.size() == 0)
            begin
                report("result word with nothing expected");
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d want %0d", got.status, want.status));
            if (got.new_task_id !== want.new_task_id)
                report($sformatf("new_task_id %0d want %0d", got.new_task_id,
                                 want.new_task_id));
            if (got.active_valid !== want.active_valid)
                report($sformatf("active_valid %0b want %0b", got.active_valid,
                                 want.active_valid));
            if (got.active_task_id !== want.active_task_id)
                report($sformatf("active_task_id %0d want %0d", got.active_task_id,
                                 want.active_task_id));
            if (got.switched !== want.switched)
                report($sformatf("switched %0b want %0b", got.switched, want.switched));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    sched_req_t request;
    logic       busy;
    logic       done;
    sched_rsp_t result;
    int         cycles;
    sched_scoreboard sb;

    priority_task_scheduler_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("[priority_task_scheduler_top] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(result);

    task automatic send_word(logic [2:0] fn, logic [3:0] tid, logic [3:0] pr,
                             logic [3:0] rs, bit gaps);
        sched_req_t rq;
        int gap;
        rq.func = fn;
        rq.task_id = tid;
        rq.priority_req = pr;
        rq.block_reason = rs;
        if (gaps && $urandom_range(0, 2) == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(rq);
    endtask

    function automatic logic [3:0] pick_slot();
        logic [3:0] s;
        s = 4'($urandom_range(0, MAX_TASKS - 1));
        for (int k = 0; k < 8; k++)
            if (sb.slot_st[s] == SS_FREE)
                s = 4'($urandom_range(0, MAX_TASKS - 1));
        return s;
    endfunction

    initial
    begin
        logic [3:0] s;
        int op;
        int w;
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(FN_SCHEDULE, 4'd0, 4'd0, 4'd0, 0);
        send_word(FN_YIELD, 4'd0, 4'd0, 4'd0, 0);
        send_word(FN_BLOCK, 4'd0, 4'd0, 4'd15, 0);
        send_word(FN_UNBLOCK, 4'd15, 4'd0, 4'd0, 0);
        send_word(FN_DESTROY, 4'd0, 4'd0, 4'd0, 0);
        send_word(FN_CREATE, 4'd0, 4'd8, 4'd0, 0);
        send_word(FN_CREATE, 4'd0, 4'd15, 4'd0, 0);
        send_word(FN_CREATE, 4'd15, 4'd0, 4'd15, 0);
        send_word(FN_CREATE, 4'd0, 4'd7, 4'd0, 0);
        send_word(FN_CREATE, 4'd0, 4'd7, 4'd0, 0);
        send_word(FN_SCHEDULE, 4'd0, 4'd0, 4'd0, 0);
        send_word(FN_BLOCK, 4'd0, 4'd0, 4'd9, 0);
        send_word(FN_UNBLOCK, 4'd1, 4'd0, 4'd8, 0);
        send_word(FN_UNBLOCK, 4'd1, 4'd0, 4'd9, 0);
        send_word(FN_BLOCK, 4'd0, 4'd0, 4'd5, 0);
        send_word(FN_YIELD, 4'd0, 4'd0, 4'd0, 0);
        send_word(FN_SCHEDULE, 4'd0, 4'd0, 4'd0, 0);
        send_word(FN_DESTROY, 4'd0, 4'd0, 4'd0, 0);
        send_word(FN_DESTROY, 4'd2, 4'd0, 4'd0, 0);
        send_word(3'd6, 4'd0, 4'd0, 4'd0, 0);
        send_word(3'd7, 4'd15, 4'd15, 4'd15, 0);
        for (int i = 0; i < 17; i++)
            send_word(FN_CREATE, 4'd0, 4'(i % PRIORITY_LEVELS), 4'd0, 0);
        send_word(FN_UNBLOCK, 4'd3, 4'd0, 4'd0, 0);

        for (int n = 0; n < 1900; n++)
        begin
            w = $urandom_range(0, 99);
            s = pick_slot();
            if (w < 22)
                op = FN_CREATE;
            else if (w < 30)
                op = FN_YIELD;
            else if (w < 40)
                op = FN_BLOCK;
            else if (w < 55)
                op = FN_UNBLOCK;
            else if (w < 70)
                op = FN_DESTROY;
            else if (w < 97)
                op = FN_SCHEDULE;
            else
                op = $urandom_range(6, 7);
            if (op == FN_UNBLOCK && $urandom_range(0, 3) != 0)
                send_word(3'(op), s, 4'($urandom_range(0, 15)), sb.slot_rs[s], 1);
            else
                send_word(3'(op), s,
                          4'($urandom_range(0, 9) == 0 ? $urandom_range(8, 15)
                                                       : $urandom_range(0, 7)),
                          4'($urandom_range(0, 15)), 1);
        end
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (sb.errors == 0)
            $display("[priority_task_scheduler_top] OK");
        else
            $display("[priority_task_scheduler_top] ERROR");
        $finish;
    end

endmodule
